/* rtl/semaphore_wait_queue_table_defines.svh */
// Assertion macros for the semaphore wait queue table.
// Used by modules that check their own control logic; no other dependencies.
`ifndef SEMAPHORE_WAIT_QUEUE_TABLE_DEFINES_SVH
`define SEMAPHORE_WAIT_QUEUE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define SWQT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SWQT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SWQT_ASSERT(lbl, prop, msg)
`define SWQT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* rtl/swqt_pkg.sv */
// Shared types and constants for the semaphore wait queue table.
// No dependencies.
package swqt_pkg;

  localparam int SWQT_NUM_PROCS = 32;
  localparam int SWQT_KEY_BITS  = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_OUT    = 2'd2,
    OP_PEEK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_KEYWT,
    S_SCAN,
    S_RM_WT,
    S_INS_LINK,
    S_INS_KEY,
    S_NEW,
    S_WALK,
    S_WALK_WT,
    S_PN_WT,
    S_DONE
  } state_t;

  // field write enables of the descriptor memory
  typedef struct packed {
    logic key;
    logic head;
    logic tail;
  } desc_we_t;

  // field write enables of the process memory
  typedef struct packed {
    logic nxt;
    logic bkey;
  } proc_we_t;

endpackage

/* rtl/swqt_desc_store.sv */
// Descriptor memory: key, queue head and queue tail per descriptor.
// One registered read port, one write port with field enables; uses swqt_pkg.
module swqt_desc_store #(
  parameter int NUM_PROCS = swqt_pkg::SWQT_NUM_PROCS,
  parameter int KEY_BITS  = swqt_pkg::SWQT_KEY_BITS
) (
  input  logic                         clk,
  input  logic [$clog2(NUM_PROCS)-1:0] raddr,
  output logic [KEY_BITS-1:0]          rkey,
  output logic [$clog2(NUM_PROCS)-1:0] rhead,
  output logic [$clog2(NUM_PROCS)-1:0] rtail,
  input  logic [$clog2(NUM_PROCS)-1:0] waddr,
  input  swqt_pkg::desc_we_t           we,
  input  logic [KEY_BITS-1:0]          wkey,
  input  logic [$clog2(NUM_PROCS)-1:0] whead,
  input  logic [$clog2(NUM_PROCS)-1:0] wtail
);
  import swqt_pkg::*;

  localparam int PW = $clog2(NUM_PROCS);

  logic [KEY_BITS-1:0] key_mem  [NUM_PROCS];
  logic [PW-1:0]       head_mem [NUM_PROCS];
  logic [PW-1:0]       tail_mem [NUM_PROCS];

  always_ff @(posedge clk) begin
    if (we.key)  key_mem[waddr]  <= wkey;
    if (we.head) head_mem[waddr] <= whead;
    if (we.tail) tail_mem[waddr] <= wtail;
    rkey  <= key_mem[raddr];
    rhead <= head_mem[raddr];
    rtail <= tail_mem[raddr];
  end

endmodule

/* rtl/swqt_proc_store.sv */
// Process memory: queue link and blocking key per process.
// One registered read port, one write port with field enables; uses swqt_pkg.
module swqt_proc_store #(
  parameter int NUM_PROCS = swqt_pkg::SWQT_NUM_PROCS,
  parameter int KEY_BITS  = swqt_pkg::SWQT_KEY_BITS
) (
  input  logic                         clk,
  input  logic [$clog2(NUM_PROCS)-1:0] raddr,
  output logic [$clog2(NUM_PROCS)-1:0] rnxt,
  output logic [KEY_BITS-1:0]          rbkey,
  input  logic [$clog2(NUM_PROCS)-1:0] waddr,
  input  swqt_pkg::proc_we_t           we,
  input  logic [$clog2(NUM_PROCS)-1:0] wnxt,
  input  logic [KEY_BITS-1:0]          wbkey
);
  import swqt_pkg::*;

  localparam int PW = $clog2(NUM_PROCS);

  logic [PW-1:0]       nxt_mem  [NUM_PROCS];
  logic [KEY_BITS-1:0] bkey_mem [NUM_PROCS];

  always_ff @(posedge clk) begin
    if (we.nxt)  nxt_mem[waddr]  <= wnxt;
    if (we.bkey) bkey_mem[waddr] <= wbkey;
    rnxt  <= nxt_mem[raddr];
    rbkey <= bkey_mem[raddr];
  end

endmodule

/* rtl/swqt_ctrl.sv */
// Sequencer of the semaphore wait queue table: scan, link and unlink steps.
// Drives both memories; holds active and blocked bits; uses swqt_pkg.
`include "semaphore_wait_queue_table_defines.svh"
module swqt_ctrl #(
  parameter int NUM_PROCS = swqt_pkg::SWQT_NUM_PROCS,
  parameter int KEY_BITS  = swqt_pkg::SWQT_KEY_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  swqt_pkg::op_t                op_in,
  input  logic [KEY_BITS-1:0]          key_in,
  input  logic [4:0]                   pid_in,
  output logic                         ready,
  output logic                         done,
  input  logic                         done_ack,
  output swqt_pkg::status_t            res_status,
  output logic [4:0]                   res_proc,
  output logic                         res_valid,
  output logic [$clog2(NUM_PROCS)-1:0] d_raddr,
  input  logic [KEY_BITS-1:0]          d_rkey,
  input  logic [$clog2(NUM_PROCS)-1:0] d_rhead,
  input  logic [$clog2(NUM_PROCS)-1:0] d_rtail,
  output logic [$clog2(NUM_PROCS)-1:0] d_waddr,
  output swqt_pkg::desc_we_t           d_we,
  output logic [KEY_BITS-1:0]          d_wkey,
  output logic [$clog2(NUM_PROCS)-1:0] d_whead,
  output logic [$clog2(NUM_PROCS)-1:0] d_wtail,
  output logic [$clog2(NUM_PROCS)-1:0] p_raddr,
  input  logic [$clog2(NUM_PROCS)-1:0] p_rnxt,
  input  logic [KEY_BITS-1:0]          p_rbkey,
  output logic [$clog2(NUM_PROCS)-1:0] p_waddr,
  output swqt_pkg::proc_we_t           p_we,
  output logic [$clog2(NUM_PROCS)-1:0] p_wnxt,
  output logic [KEY_BITS-1:0]          p_wbkey
);
  import swqt_pkg::*;

  localparam int PW = $clog2(NUM_PROCS);
  localparam logic [PW:0]   CNT_END  = (PW + 1)'(NUM_PROCS);
  localparam logic [PW-1:0] LAST_IDX = PW'(NUM_PROCS - 1);

  state_t              state, state_next;
  op_t                 op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [4:0]          pid_r;
  logic [PW:0]         cnt;
  logic                rd_vld;
  logic [PW-1:0]       rd_idx;
  logic                free_vld;
  logic [PW-1:0]       free_idx;
  logic [PW-1:0]       d_r, h_r, t_r, cur, prev;
  logic                has_prev;
  logic [NUM_PROCS-1:0] active, blocked;

  logic          p_idx_ok;
  logic [PW-1:0] p_idx;
  logic          key_zero, match, scan_end, issue;

  // combinational control outputs
  logic          res_ld;
  status_t       res_st_n;
  logic [4:0]    res_pr_n;
  logic          res_vl_n;
  logic          act_set, act_clr, blk_set, blk_clr;
  logic [PW-1:0] act_idx, blk_idx;

  assign p_idx    = PW'(pid_r);
  assign p_idx_ok = (32'(pid_r) < 32'(NUM_PROCS));
  assign key_zero = (key_r == '0);
  assign issue    = (cnt < CNT_END);
  assign match    = rd_vld && active[rd_idx] && (d_rkey == key_r);
  assign scan_end = rd_vld && (rd_idx == LAST_IDX) && !match;

  assign ready = (state == S_IDLE);
  assign done  = (state == S_DONE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_CHECK;
      end
      S_CHECK: begin
        unique case (op_r)
          OP_INSERT: begin
            if (key_zero || !p_idx_ok || blocked[p_idx]) state_next = S_DONE;
            else state_next = S_SCAN;
          end
          OP_REMOVE, OP_PEEK: begin
            state_next = key_zero ? S_DONE : S_SCAN;
          end
          OP_OUT: begin
            if (!p_idx_ok || !blocked[p_idx]) state_next = S_DONE;
            else state_next = S_KEYWT;
          end
        endcase
      end
      S_KEYWT: state_next = S_SCAN;
      S_SCAN: begin
        if (match) begin
          unique case (op_r)
            OP_INSERT: state_next = S_INS_LINK;
            OP_REMOVE: state_next = (d_rhead == d_rtail) ? S_DONE : S_RM_WT;
            OP_OUT:    state_next = S_WALK;
            OP_PEEK:   state_next = S_DONE;
          endcase
        end else if (scan_end) begin
          state_next = (op_r == OP_INSERT && free_vld) ? S_NEW : S_DONE;
        end
      end
      S_RM_WT:    state_next = S_DONE;
      S_INS_LINK: state_next = S_INS_KEY;
      S_INS_KEY:  state_next = S_DONE;
      S_NEW:      state_next = S_DONE;
      S_WALK: begin
        if (cur == p_idx) state_next = (!has_prev && t_r == p_idx) ? S_DONE : S_PN_WT;
        else if (cur == t_r) state_next = S_DONE;
        else state_next = S_WALK_WT;
      end
      S_WALK_WT: state_next = S_WALK;
      S_PN_WT:   state_next = S_DONE;
      S_DONE: begin
        if (done_ack) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory ports, flag updates and result loads
  always_comb begin
    d_raddr  = cnt[PW-1:0];
    d_waddr  = d_r;
    d_we     = '0;
    d_wkey   = key_r;
    d_whead  = p_idx;
    d_wtail  = p_idx;
    p_raddr  = p_idx;
    p_waddr  = p_idx;
    p_we     = '0;
    p_wnxt   = p_idx;
    p_wbkey  = key_r;
    res_ld   = 1'b0;
    res_st_n = ST_OK;
    res_pr_n = '0;
    res_vl_n = 1'b0;
    act_set  = 1'b0;
    act_clr  = 1'b0;
    act_idx  = d_r;
    blk_set  = 1'b0;
    blk_clr  = 1'b0;
    blk_idx  = p_idx;
    unique case (state)
      S_CHECK: begin
        unique case (op_r)
          OP_INSERT: begin
            if (key_zero) begin
              res_ld = 1'b1;
            end else if (!p_idx_ok || blocked[p_idx]) begin
              res_ld   = 1'b1;
              res_st_n = ST_NOTFOUND;
            end
          end
          OP_REMOVE, OP_PEEK: begin
            if (key_zero) begin
              res_ld   = 1'b1;
              res_st_n = ST_NOTFOUND;
            end
          end
          OP_OUT: begin
            if (!p_idx_ok || !blocked[p_idx]) begin
              res_ld   = 1'b1;
              res_st_n = ST_NOTFOUND;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (match) begin
          if (op_r == OP_REMOVE) begin
            if (d_rhead == d_rtail) begin
              act_clr  = 1'b1;
              act_idx  = rd_idx;
              blk_clr  = 1'b1;
              blk_idx  = d_rhead;
              res_ld   = 1'b1;
              res_pr_n = 5'(d_rhead);
              res_vl_n = 1'b1;
            end else begin
              p_raddr = d_rhead;
            end
          end else if (op_r == OP_PEEK) begin
            res_ld   = 1'b1;
            res_pr_n = 5'(d_rhead);
            res_vl_n = 1'b1;
          end
        end else if (scan_end) begin
          if (op_r == OP_INSERT) begin
            if (!free_vld) begin
              res_ld   = 1'b1;
              res_st_n = ST_FULL;
            end
          end else begin
            res_ld   = 1'b1;
            res_st_n = ST_NOTFOUND;
          end
        end
      end
      S_RM_WT: begin
        d_we.head = 1'b1;
        d_whead   = p_rnxt;
        blk_clr   = 1'b1;
        blk_idx   = h_r;
        res_ld    = 1'b1;
        res_pr_n  = 5'(h_r);
        res_vl_n  = 1'b1;
      end
      S_INS_LINK: begin
        p_we.nxt  = 1'b1;
        p_waddr   = t_r;
        d_we.tail = 1'b1;
      end
      S_INS_KEY: begin
        p_we.bkey = 1'b1;
        blk_set   = 1'b1;
        res_ld    = 1'b1;
      end
      S_NEW: begin
        d_we      = '1;
        d_waddr   = free_idx;
        act_set   = 1'b1;
        act_idx   = free_idx;
        p_we.bkey = 1'b1;
        blk_set   = 1'b1;
        res_ld    = 1'b1;
      end
      S_WALK: begin
        if (cur == p_idx) begin
          if (!has_prev && t_r == p_idx) begin
            act_clr  = 1'b1;
            blk_clr  = 1'b1;
            res_ld   = 1'b1;
            res_pr_n = pid_r;
            res_vl_n = 1'b1;
          end
        end else if (cur == t_r) begin
          res_ld   = 1'b1;
          res_st_n = ST_NOTFOUND;
        end else begin
          p_raddr = cur;
        end
      end
      S_PN_WT: begin
        if (!has_prev) begin
          d_we.head = 1'b1;
          d_whead   = p_rnxt;
        end else begin
          p_we.nxt = 1'b1;
          p_waddr  = prev;
          p_wnxt   = p_rnxt;
          if (t_r == p_idx) begin
            d_we.tail = 1'b1;
            d_wtail   = prev;
          end
        end
        blk_clr  = 1'b1;
        res_ld   = 1'b1;
        res_pr_n = pid_r;
        res_vl_n = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      active  <= '0;
      blocked <= '0;
    end else begin
      state <= state_next;
      if (act_set) active[act_idx] <= 1'b1;
      if (act_clr) active[act_idx] <= 1'b0;
      if (blk_set) blocked[blk_idx] <= 1'b1;
      if (blk_clr) blocked[blk_idx] <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= op_in;
      key_r <= key_in;
      pid_r <= pid_in;
    end
    if (res_ld) begin
      res_status <= res_st_n;
      res_proc   <= res_pr_n;
      res_valid  <= res_vl_n;
    end
    unique case (state)
      S_CHECK: begin
        cnt      <= '0;
        rd_vld   <= 1'b0;
        free_vld <= 1'b0;
      end
      S_KEYWT: key_r <= p_rbkey;
      S_SCAN: begin
        // issue one descriptor read per cycle; compare the one read last cycle
        rd_vld <= issue;
        rd_idx <= cnt[PW-1:0];
        if (issue) begin
          cnt <= cnt + 1'b1;
          if (!free_vld && !active[cnt[PW-1:0]]) begin
            free_vld <= 1'b1;
            free_idx <= cnt[PW-1:0];
          end
        end
        if (match) begin
          d_r      <= rd_idx;
          h_r      <= d_rhead;
          t_r      <= d_rtail;
          cur      <= d_rhead;
          has_prev <= 1'b0;
        end
      end
      S_WALK: begin
        if (cur != p_idx && cur != t_r) begin
          prev     <= cur;
          has_prev <= 1'b1;
        end
      end
      S_WALK_WT: cur <= p_rnxt;
      default: begin
      end
    endcase
  end

  `SWQT_ASSERT(a_start_idle, !start || state == S_IDLE, "item taken while busy")
  `SWQT_ASSERT_NEXT(a_done_hold, state == S_DONE && !done_ack, state == S_DONE,
    "result dropped before hand-off")
  `SWQT_ASSERT(a_new_free, state != S_NEW || !active[free_idx],
    "allocation hit an active descriptor")
  `SWQT_ASSERT(a_valid_ok, !(res_ld && res_vl_n) || res_st_n == ST_OK,
    "process reported with failing status")

endmodule

/* rtl/semaphore_wait_queue_table.sv */
// Insert, remove and peek scan the descriptors for the key, then link, unlink or report;
// out first fetches the blocking key of the process and then walks its queue link by link.
// Throughput: one item at a time, bound by the linear key scan through the single read port
// of the descriptor memory (one descriptor per cycle) and by the link walk for out.
// Reset (rst, synchronous, active high) clears the sequencer and the active and blocked bits.
module semaphore_wait_queue_table #(
  parameter int NUM_PROCS = swqt_pkg::SWQT_NUM_PROCS,
  parameter int KEY_BITS  = swqt_pkg::SWQT_KEY_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // operation[1:0], sem_key[33:2], proc_id[38:34], pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // status[1:0], result_proc[6:2], result_valid[7]
);
  import swqt_pkg::*;

  localparam int PW = $clog2(NUM_PROCS);

  logic                start, done, done_ack, ready;
  logic [63:0]         key_wide;
  logic [KEY_BITS-1:0] key_in;
  status_t             res_status;
  logic [4:0]          res_proc;
  logic                res_valid;

  logic [PW-1:0]       d_raddr, d_rhead, d_rtail, d_waddr, d_whead, d_wtail;
  logic [KEY_BITS-1:0] d_rkey, d_wkey;
  desc_we_t            d_we;
  logic [PW-1:0]       p_raddr, p_rnxt, p_waddr, p_wnxt;
  logic [KEY_BITS-1:0] p_rbkey, p_wbkey;
  proc_we_t            p_we;

  // take an item only while the sequencer is idle
  assign s_axis_tready = ready;
  assign start         = s_axis_tvalid && s_axis_tready;

  // mask the key to the configured key width
  assign key_wide = {32'b0, s_axis_tdata[33:2]};
  assign key_in   = key_wide[KEY_BITS-1:0];

  // output register: free when empty or being drained this cycle
  assign done_ack = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done && done_ack) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // hold the payload until its transfer completes
  always_ff @(posedge clk) begin
    if (done && done_ack) begin
      m_axis_tdata <= {res_valid, res_proc, res_status};
    end
  end

  swqt_ctrl #(
    .NUM_PROCS(NUM_PROCS),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op_in     (op_t'(s_axis_tdata[1:0])),
    .key_in    (key_in),
    .pid_in    (s_axis_tdata[38:34]),
    .ready     (ready),
    .done      (done),
    .done_ack  (done_ack),
    .res_status(res_status),
    .res_proc  (res_proc),
    .res_valid (res_valid),
    .d_raddr   (d_raddr),
    .d_rkey    (d_rkey),
    .d_rhead   (d_rhead),
    .d_rtail   (d_rtail),
    .d_waddr   (d_waddr),
    .d_we      (d_we),
    .d_wkey    (d_wkey),
    .d_whead   (d_whead),
    .d_wtail   (d_wtail),
    .p_raddr   (p_raddr),
    .p_rnxt    (p_rnxt),
    .p_rbkey   (p_rbkey),
    .p_waddr   (p_waddr),
    .p_we      (p_we),
    .p_wnxt    (p_wnxt),
    .p_wbkey   (p_wbkey)
  );

  swqt_desc_store #(
    .NUM_PROCS(NUM_PROCS),
    .KEY_BITS (KEY_BITS)
  ) u_desc (
    .clk  (clk),
    .raddr(d_raddr),
    .rkey (d_rkey),
    .rhead(d_rhead),
    .rtail(d_rtail),
    .waddr(d_waddr),
    .we   (d_we),
    .wkey (d_wkey),
    .whead(d_whead),
    .wtail(d_wtail)
  );

  swqt_proc_store #(
    .NUM_PROCS(NUM_PROCS),
    .KEY_BITS (KEY_BITS)
  ) u_proc (
    .clk  (clk),
    .raddr(p_raddr),
    .rnxt (p_rnxt),
    .rbkey(p_rbkey),
    .waddr(p_waddr),
    .we   (p_we),
    .wnxt (p_wnxt),
    .wbkey(p_wbkey)
  );

endmodule

/* sim/semaphore_wait_queue_table_checker.sv */
// Checker for the semaphore wait queue table: watches both stream channels,
// predicts each result from its own copy of the table and compares. Uses swqt_pkg.
module semaphore_wait_queue_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  output int          fail_count,
  output int          pending
);
  import swqt_pkg::*;

  localparam int NP = SWQT_NUM_PROCS;

  typedef struct packed {
    status_t    status;
    logic [4:0] proc_out;
    logic       proc_valid;
  } sem_result_t;

  logic [31:0] key_of [NP];
  logic        active [NP];
  logic [4:0]  head_of [NP];
  logic [4:0]  tail_of [NP];
  logic [4:0]  next_of [NP];
  logic [31:0] waits_on [NP];

  sem_result_t expected_results [$];

  function automatic int lookup(logic [31:0] k);
    for (int d = 0; d < NP; d++)
      if (active[d] && key_of[d] == k) return d;
    return -1;
  endfunction

  function automatic sem_result_t mk(status_t st, logic [4:0] p, logic v);
    sem_result_t r;
    r.status = st;
    r.proc_out = v ? p : 5'd0;
    r.proc_valid = v;
    return r;
  endfunction

  // Advance the predicted table by one operation and return its result.
  function automatic sem_result_t predict_semaphore(op_t op, logic [31:0] k, logic [4:0] p);
    int d;
    int f;
    logic [4:0] cur;
    logic [4:0] prev;
    logic [4:0] h;
    bit has_prev;
    bit found;
    case (op)
      OP_INSERT: begin
        if (k == '0) return mk(ST_OK, 5'd0, 1'b0);
        if (waits_on[p] != '0) return mk(ST_NOTFOUND, 5'd0, 1'b0);
        d = lookup(k);
        if (d >= 0) begin
          next_of[tail_of[d]] = p;
          tail_of[d] = p;
        end else begin
          f = -1;
          for (int i = NP - 1; i >= 0; i--)
            if (!active[i]) f = i;
          if (f < 0) return mk(ST_FULL, 5'd0, 1'b0);
          active[f] = 1'b1;
          key_of[f] = k;
          head_of[f] = p;
          tail_of[f] = p;
        end
        waits_on[p] = k;
        return mk(ST_OK, 5'd0, 1'b0);
      end
      OP_REMOVE: begin
        d = (k == '0) ? -1 : lookup(k);
        if (d < 0) return mk(ST_NOTFOUND, 5'd0, 1'b0);
        h = head_of[d];
        if (h == tail_of[d]) active[d] = 1'b0;
        else head_of[d] = next_of[h];
        waits_on[h] = '0;
        return mk(ST_OK, h, 1'b1);
      end
      OP_OUT: begin
        d = (waits_on[p] == '0) ? -1 : lookup(waits_on[p]);
        if (d < 0) return mk(ST_NOTFOUND, 5'd0, 1'b0);
        cur = head_of[d];
        prev = '0;
        has_prev = 0;
        found = 0;
        for (int n = 0; n < NP; n++) begin
          if (cur == p) begin
            found = 1;
            break;
          end
          if (cur == tail_of[d]) break;
          prev = cur;
          has_prev = 1;
          cur = next_of[cur];
        end
        if (!found) return mk(ST_NOTFOUND, 5'd0, 1'b0);
        if (head_of[d] == p && tail_of[d] == p) active[d] = 1'b0;
        else if (!has_prev) head_of[d] = next_of[p];
        else begin
          next_of[prev] = next_of[p];
          if (tail_of[d] == p) tail_of[d] = prev;
        end
        waits_on[p] = '0;
        return mk(ST_OK, p, 1'b1);
      end
      default: begin
        d = (k == '0) ? -1 : lookup(k);
        if (d < 0) return mk(ST_NOTFOUND, 5'd0, 1'b0);
        return mk(ST_OK, head_of[d], 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    sem_result_t got;
    sem_result_t exp_r;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
      expected_results.delete();
      for (int i = 0; i < NP; i++) begin
        active[i] = 1'b0;
        waits_on[i] = '0;
        key_of[i] = '0;
        head_of[i] = '0;
        tail_of[i] = '0;
        next_of[i] = '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status     = status_t'(m_axis_tdata[1:0]);
        got.proc_out   = m_axis_tdata[6:2];
        got.proc_valid = m_axis_tdata[7];
        if (expected_results.size() == 0) begin
          $error("result with no expectation: %h", m_axis_tdata);
          errs++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status != exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, got.status);
            errs++;
          end
          if (got.proc_out != exp_r.proc_out) begin
            $error("result_proc: expected %0d actual %0d", exp_r.proc_out, got.proc_out);
            errs++;
          end
          if (got.proc_valid != exp_r.proc_valid) begin
            $error("result_valid: expected %0d actual %0d", exp_r.proc_valid,
                   got.proc_valid);
            errs++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_semaphore(op_t'(s_axis_tdata[1:0]),
                                                     s_axis_tdata[33:2], s_axis_tdata[38:34]));
      if (errs != 0) fail_count <= fail_count + errs;
    end
    pending <= expected_results.size();
  end
endmodule

/* sim/tb_semaphore_wait_queue_table.sv */
// Top of the semaphore wait queue table bench: clock, reset, stimulus and verdict.
// Depends on swqt_pkg, the block and semaphore_wait_queue_table_checker.
module tb_semaphore_wait_queue_table;
  import swqt_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CALM_TAIL    = 200;     // last items run with no idling
  localparam int STALL_LIMIT  = 2000;    // cycles with no transfer before giving up

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [7:0]  m_axis_tdata;
  int          fail_count;
  int          pending;
  bit          calm = 0;
  int          quiet_cycles = 0;

  // Small key pool so inserts, removes and peeks collide on live descriptors.
  logic [31:0] key_pool [8];

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  semaphore_wait_queue_table dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  semaphore_wait_queue_table_checker chk (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .fail_count, .pending
  );

  // Watchdog: end the run if nothing transfers for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("tb_semaphore_wait_queue_table failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Receiver: stall in random bursts, none once calm is set.
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 6);
        repeat (n) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        n = $urandom_range(1, 12);
        repeat (n) @(negedge clk);
      end
    end
  end

  // Drive one item and hold it until the transfer; optionally idle first.
  // Valid stays up after the transfer until the next call or an explicit drop;
  // the block is busy by then, so the stale item is never taken.
  task automatic send_op(op_t op, logic [31:0] k, logic [4:0] p);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, p, k, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int roll;
    op_t op;
    logic [31:0] k;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom_range(1, 1000);
    key_pool[7] = 32'hFFFF_FFFF;
    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: key zero, extremes, double block, not-found cases.
    send_op(OP_INSERT, 32'd0, 5'd3);
    send_op(OP_REMOVE, 32'd0, 5'd0);
    send_op(OP_PEEK, 32'd0, 5'd0);
    send_op(OP_OUT, 32'd5, 5'd31);
    send_op(OP_INSERT, 32'hFFFF_FFFF, 5'd31);
    send_op(OP_INSERT, 32'hFFFF_FFFF, 5'd0);
    send_op(OP_INSERT, 32'd1, 5'd31);
    send_op(OP_PEEK, 32'hFFFF_FFFF, 5'd0);
    send_op(OP_REMOVE, 32'd77, 5'd0);
    send_op(OP_OUT, 32'd0, 5'd0);
    send_op(OP_REMOVE, 32'hFFFF_FFFF, 5'd0);
    send_op(OP_PEEK, 32'hFFFF_FFFF, 5'd0);
    // Fill every descriptor with its own key; the last insert takes the last free one.
    for (int p = 1; p < 32; p++) send_op(OP_INSERT, 32'h100 + p, p[4:0]);
    send_op(OP_INSERT, 32'hAAAA_5555, 5'd0);
    // Full table: take proc 17 out, queue it behind proc 1 on key 0x101, then peek.
    send_op(OP_OUT, 32'd0, 5'd17);
    send_op(OP_INSERT, 32'h101, 5'd17);
    send_op(OP_PEEK, 32'h101, 5'd0);
    for (int p = 1; p < 32; p++) send_op(OP_OUT, 32'd0, p[4:0]);
    // Hold off until every result is back.
    s_axis_tvalid <= 1'b0;
    drain_results();

    // Random: mostly pool keys so queues grow and shrink, some wild keys.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_TAIL) calm = 1;
      roll = $urandom_range(0, 9);
      op = (roll < 4) ? OP_INSERT : (roll < 6) ? OP_REMOVE : (roll < 8) ? OP_OUT : OP_PEEK;
      if ($urandom_range(0, 9) == 0) k = $urandom;
      else if ($urandom_range(0, 19) == 0) k = 32'd0;
      else k = key_pool[$urandom_range(0, 7)];
      send_op(op, k, 5'($urandom_range(0, 31)));
    end

    s_axis_tvalid <= 1'b0;
    drain_results();
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_semaphore_wait_queue_table passed");
    else
      $display("tb_semaphore_wait_queue_table failed");
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/swqt_pkg.sv
rtl/swqt_desc_store.sv
rtl/swqt_proc_store.sv
rtl/swqt_ctrl.sv
rtl/semaphore_wait_queue_table.sv
sim/semaphore_wait_queue_table_checker.sv
sim/tb_semaphore_wait_queue_table.sv
